// ===== src/wheel_scroll_smoother_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Wheel scroll smoother assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef WHEEL_SCROLL_SMOOTHER_UNIT_DEFINES_SVH
`define WHEEL_SCROLL_SMOOTHER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define WSS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("wss: assertion failed");
// condition must never be true outside reset
`define WSS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("wss: forbidden condition seen");
`else
`define WSS_ASSERT(lbl, clk, rst_n, prop)
`define WSS_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== src/wss_pkg.sv =====
// ----------------------------------------------------------------------------
// wss_pkg
// Shared types, constants and the raised-cosine weight table of the wheel
// scroll smoother.
// ----------------------------------------------------------------------------
package wss_pkg;

  // sizing defaults
  localparam int unsigned PendingDepthDef = 32;
  localparam int unsigned RecentCapDef    = 15;
  localparam int unsigned RampSteps       = 24;

  // field widths
  localparam int unsigned DeltaW   = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned WindowW  = 16;
  localparam int unsigned GainW    = 4;
  localparam int unsigned ScrollW  = 22;
  localparam int unsigned AmtW     = 24;
  localparam int unsigned StepW    = 5;
  localparam int unsigned WeightW  = 17;

  // boost and divide-by-six datapath
  localparam int unsigned FactW    = 9;
  localparam int unsigned DivW     = 26;
  localparam logic [FactW-1:0] RunBase  = 9'd6;
  // ceil(2^DivW / 3): exact divide by three for a dividend below 2^(DivW-1)
  localparam logic [DivW-2:0]  Recip3   = 25'd22369622;
  // 3 for round half up, plus 6 * 2^22 to keep the dividend positive
  localparam logic [DivW-1:0]  DivBias  = 26'd25165827;
  localparam logic [DivW-1:0]  QOffset  = 26'd4194304;

  // configuration port
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgWindowMs = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgAltGain  = 1'b1;
  localparam logic [WindowW-1:0] WindowMsRst = 16'd500;
  localparam logic [GainW-1:0]   AltGainRst  = 4'd5;

  // item kinds
  localparam logic KindNotch = 1'b0;
  localparam logic KindTick  = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic signed [DeltaW-1:0] wheel_delta;
    logic [TimeW-1:0]         time_ms;
    logic                     alt_held;
  } wss_in_t;

  typedef struct packed {
    logic signed [ScrollW-1:0] scroll_amount;
    logic                      busy_res;
    logic                      dropped;
  } wss_out_t;

  // control toward the pending queue
  typedef struct packed {
    logic                   push;
    logic                   tick;
    logic signed [AmtW-1:0] amount;
  } wss_q_cmd_t;

  // status back from the pending queue
  typedef struct packed {
    logic                      full;
    logic                      done;
    logic                      nonempty;
    logic signed [ScrollW-1:0] amount;
  } wss_q_sts_t;

  // Q16 weight per steps-left value, zero outside 1..RampSteps
  typedef logic [WeightW-1:0] weight_lut_t [0:(1<<StepW)-1];

  localparam logic [63:0] PiQ30  = 64'd3373259426;
  localparam longint      OneQ30 = 64'sd1073741824;

  // Truncating Taylor cosine in Q30, squared, scaled by 2/RampSteps, rounded
  function automatic weight_lut_t build_weight_lut();
    weight_lut_t lut;
    logic [63:0] d;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] cu;
    logic [63:0] c2;
    longint      c;
    for (int s = 0; s < (1 << StepW); s++) begin
      lut[s] = '0;
      if (s >= 1 && s <= int'(RampSteps)) begin
        if (2 * s > int'(RampSteps)) begin
          d = 64'(2 * s - int'(RampSteps));
        end else begin
          d = 64'(int'(RampSteps) - 2 * s);
        end
        a    = (PiQ30 * d) / 64'(2 * RampSteps);
        a2   = (a * a) >> 30;
        c    = OneQ30;
        term = 64'(OneQ30);
        // ten series terms, term k divided by (2k-1)*2k, signs alternate
        term = ((term * a2) >> 30) / 64'd2;
        c    = c - longint'(term);
        term = ((term * a2) >> 30) / 64'd12;
        c    = c + longint'(term);
        term = ((term * a2) >> 30) / 64'd30;
        c    = c - longint'(term);
        term = ((term * a2) >> 30) / 64'd56;
        c    = c + longint'(term);
        term = ((term * a2) >> 30) / 64'd90;
        c    = c - longint'(term);
        term = ((term * a2) >> 30) / 64'd132;
        c    = c + longint'(term);
        term = ((term * a2) >> 30) / 64'd182;
        c    = c - longint'(term);
        term = ((term * a2) >> 30) / 64'd240;
        c    = c + longint'(term);
        term = ((term * a2) >> 30) / 64'd306;
        c    = c - longint'(term);
        term = ((term * a2) >> 30) / 64'd380;
        c    = c + longint'(term);
        if (c < 0) c = 0;
        if (c > OneQ30) c = OneQ30;
        cu     = 64'(c);
        c2     = (cu * cu) >> 30;
        lut[s] = WeightW'((((c2 << 17) / 64'(RampSteps)) + (64'd1 << 29)) >> 30);
      end
    end
    return lut;
  endfunction

  localparam weight_lut_t WeightLut = build_weight_lut();

endpackage

// ===== src/wss_pending_queue.sv =====
// ----------------------------------------------------------------------------
// wss_pending_queue
// Circular queue of pending impulses held in a single-port-write RAM. A tick
// walks the live entries one per cycle through a read / multiply / accumulate
// pipeline, writes back the decremented step count and retires spent entries.
// ----------------------------------------------------------------------------
`include "wheel_scroll_smoother_unit_defines.svh"

module wss_pending_queue #(
  parameter int unsigned PendingDepth = wss_pkg::PendingDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wss_pkg::wss_q_cmd_t cmd_i,
  output wss_pkg::wss_q_sts_t sts_o
);
  import wss_pkg::*;

  localparam int unsigned PtrW   = (PendingDepth > 1) ? $clog2(PendingDepth) : 1;
  localparam int unsigned CntW   = $clog2(PendingDepth + 1);
  localparam int unsigned SumW   = CntW + 1;
  localparam int unsigned EntryW = AmtW + StepW;
  localparam int unsigned ProdW  = AmtW + WeightW + 1;
  localparam int unsigned AccW   = ProdW + CntW;

  localparam logic [PtrW-1:0] LastPtr = PtrW'(PendingDepth - 1);
  localparam logic [SumW-1:0] DepthS  = SumW'(PendingDepth);
  localparam logic [CntW-1:0] DepthC  = CntW'(PendingDepth);
  localparam logic signed [AccW-1:0] RoundHalf = AccW'(32768);
  localparam logic signed [AccW-1:0] SatHi = AccW'((64'd1 << (ScrollW - 1)) - 64'd1);
  localparam logic signed [AccW-1:0] SatLo = ~SatHi;

  localparam logic [1:0] Q_IDLE = 2'd0;
  localparam logic [1:0] Q_WALK = 2'd1;
  localparam logic [1:0] Q_FIN  = 2'd2;

  // pointer plus count, modulo the queue depth
  function automatic logic [PtrW-1:0] wrap_add(input logic [PtrW-1:0] ptr,
                                               input logic [CntW-1:0] cnt);
    logic [SumW-1:0] sum;
    sum = SumW'(ptr) + SumW'(cnt);
    if (sum >= DepthS) begin
      sum = sum - DepthS;
    end
    return sum[PtrW-1:0];
  endfunction

  logic [1:0]             state_q, state_d;
  logic [PtrW-1:0]        head_q;
  logic [CntW-1:0]        fill_q;
  logic [PtrW-1:0]        rd_ptr_q;
  logic [CntW-1:0]        issue_q;
  logic [CntW-1:0]        retire_q;
  logic                   rd_vld_q;
  logic                   prod_vld_q;
  logic                   done_q;
  logic [EntryW-1:0]      rd_data_q;
  logic [PtrW-1:0]        wb_addr_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [ScrollW-1:0] amount_q;

  logic [EntryW-1:0]      pend_mem [PendingDepth];

  logic                   full;
  logic                   push_go;
  logic                   tick_go;
  logic                   issue_go;
  logic [PtrW-1:0]        tail;
  logic signed [AmtW-1:0] rd_amt;
  logic [StepW-1:0]       rd_steps;
  logic [StepW-1:0]       steps_dec;
  logic [WeightW-1:0]     weight;
  logic                   mem_we;
  logic [PtrW-1:0]        mem_waddr;
  logic [EntryW-1:0]      mem_wdata;
  logic signed [AccW-1:0] acc_rnd;
  logic signed [AccW-1:0] acc_shr;
  logic signed [AccW-1:0] acc_sat;

  // queue status and handshakes
  assign full      = (fill_q == DepthC);
  assign push_go   = cmd_i.push && (state_q == Q_IDLE) && !full;
  assign tick_go   = cmd_i.tick && (state_q == Q_IDLE);
  assign issue_go  = (state_q == Q_WALK) && (issue_q < fill_q);
  assign tail      = wrap_add(head_q, fill_q);

  // entry fields and weight lookup
  assign rd_amt    = rd_data_q[EntryW-1:StepW];
  assign rd_steps  = rd_data_q[StepW-1:0];
  assign steps_dec = rd_steps - StepW'(1);
  assign weight    = WeightLut[rd_steps];

  // write port: walk write-back or a new impulse
  assign mem_we    = push_go || rd_vld_q;
  assign mem_waddr = rd_vld_q ? wb_addr_q : tail;
  assign mem_wdata = rd_vld_q ? {rd_amt, steps_dec} : {cmd_i.amount, StepW'(RampSteps)};

  // round half up to whole units and saturate
  always_comb begin
    acc_rnd = acc_q + RoundHalf;
    acc_shr = acc_rnd >>> 16;
    if (acc_shr > SatHi) begin
      acc_sat = SatHi;
    end else if (acc_shr < SatLo) begin
      acc_sat = SatLo;
    end else begin
      acc_sat = acc_shr;
    end
  end

  // walk sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      Q_IDLE: begin
        if (tick_go) state_d = Q_WALK;
      end
      Q_WALK: begin
        if (!issue_go && !rd_vld_q && !prod_vld_q) state_d = Q_FIN;
      end
      Q_FIN: begin
        state_d = Q_IDLE;
      end
      default: begin
        state_d = Q_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= Q_IDLE;
      head_q     <= '0;
      fill_q     <= '0;
      rd_ptr_q   <= '0;
      issue_q    <= '0;
      retire_q   <= '0;
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      done_q     <= (state_q == Q_FIN);
      rd_vld_q   <= issue_go;
      prod_vld_q <= rd_vld_q;
      if (tick_go) begin
        issue_q  <= '0;
        retire_q <= '0;
        rd_ptr_q <= head_q;
      end
      if (issue_go) begin
        issue_q  <= issue_q + CntW'(1);
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      // entries age in lockstep, so spent ones sit at the head
      if (rd_vld_q && (steps_dec == '0)) begin
        retire_q <= retire_q + CntW'(1);
      end
      if (push_go) begin
        fill_q <= fill_q + CntW'(1);
      end
      if (state_q == Q_FIN) begin
        head_q <= wrap_add(head_q, retire_q);
        fill_q <= fill_q - retire_q;
      end
    end
  end

  // multiply and accumulate pipeline
  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      prod_q <= $signed(rd_amt) * $signed({1'b0, weight});
    end
    if (tick_go) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + {{(AccW - ProdW){prod_q[ProdW-1]}}, prod_q};
    end
    if (state_q == Q_FIN) begin
      amount_q <= acc_sat[ScrollW-1:0];
    end
  end

  // impulse RAM
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pend_mem[mem_waddr] <= mem_wdata;
    end
    if (issue_go) begin
      rd_data_q <= pend_mem[rd_ptr_q];
      wb_addr_q <= rd_ptr_q;
    end
  end

  assign sts_o.full     = full;
  assign sts_o.done     = done_q;
  assign sts_o.nonempty = (fill_q != '0);
  assign sts_o.amount   = amount_q;

  // checks
  `WSS_ASSERT_NEVER(a_fill_bound, clk_i, rst_ni, fill_q > DepthC)
  `WSS_ASSERT(a_done_drained, clk_i, rst_ni, done_q |-> (!rd_vld_q && !prod_vld_q))
  `WSS_ASSERT(a_walk_bound, clk_i, rst_ni, (state_q == Q_WALK) |-> (issue_q <= fill_q))

endmodule

// ===== src/wheel_scroll_smoother_unit.sv =====
// ----------------------------------------------------------------------------
// wheel_scroll_smoother_unit
// Turns sparse wheel notches into one smoothed scroll amount per frame tick.
//
// Usage: items enter on in_valid_i/in_ready_o, results leave on
// out_valid_o/out_ready_i, one result per item. Configuration registers
// (window_ms, alt_gain) are written through cfg_we_i/cfg_idx_i/cfg_wdata_i
// while the block is idle.
// A notch passes from transfer to result through one compare per
// recent notch in the window plus one, then boost, multiply, divide by six
// (reciprocal multiply), queue write and output register.
// A tick does one RAM read and multiply-accumulate per pending impulse.
// One item is in flight at a time; in_ready_o is high only when idle.
// The result sits in an output register, so the next item can be taken
// and processed while the previous result is still waiting; a stalled
// receiver holds off the following result only at its final step.
// Reset clears the queue, the notch history count and restores
// window_ms = 500 and alt_gain = 5; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "wheel_scroll_smoother_unit_defines.svh"

module wheel_scroll_smoother_unit #(
  parameter int unsigned PendingDepth = wss_pkg::PendingDepthDef,
  parameter int unsigned RecentCap    = wss_pkg::RecentCapDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wss_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [wss_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  wss_pkg::wss_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output wss_pkg::wss_out_t             out_data_o
);
  import wss_pkg::*;

  localparam int unsigned RunW    = $clog2(RecentCap + 1);
  localparam int unsigned IdxW    = (RecentCap > 1) ? $clog2(RecentCap) : 1;
  localparam int unsigned NumW    = DeltaW + FactW + 1;
  localparam int unsigned HalfW   = DivW - 1;
  localparam logic [RunW-1:0]    CapR    = RunW'(RecentCap);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_FACT = 3'd2;
  localparam logic [2:0] S_MULT = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_PUSH = 3'd5;
  localparam logic [2:0] S_TICK = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  logic [2:0]               state_q, state_d;
  logic [WindowW-1:0]       window_q;
  logic [GainW-1:0]         gain_q;
  logic [TimeW-1:0]         times_q [RecentCap];
  logic [RunW-1:0]          cnt_q;
  logic [RunW-1:0]          idx_q;
  logic [TimeW-1:0]         now_q;
  logic signed [DeltaW-1:0] delta_q;
  logic                     alt_q;
  logic [FactW-1:0]         fact_q;
  logic [DivW-1:0]          num_q;
  wss_out_t                 res_q;
  wss_out_t                 out_q;
  logic                     out_valid_q;

  logic                     in_fire;
  logic                     notch_fire;
  logic                     scan_hit;
  logic                     out_free;
  logic [TimeW-1:0]         age;
  logic [GainW-1:0]         gain_sel;
  logic signed [NumW-1:0]   prod_n;
  logic [2*HalfW-1:0]       recip_prod;
  logic [DivW-1:0]          quot_adj;
  wss_q_cmd_t               q_cmd;
  wss_q_sts_t               q_sts;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign notch_fire  = in_fire && (in_data_i.kind == KindNotch);
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // window scan compare: one timestamp per cycle, newest first
  assign age      = now_q - times_q[idx_q[IdxW-1:0]];
  assign scan_hit = (idx_q < cnt_q) && (age <= TimeW'(window_q));

  // boost multiply and divide by six: halve, then reciprocal of three
  assign gain_sel   = alt_q ? gain_q : GainW'(1);
  assign prod_n     = $signed(delta_q) * $signed({1'b0, fact_q});
  assign recip_prod = num_q[DivW-1:1] * Recip3;
  assign quot_adj   = num_q - QOffset;

  // queue control
  assign q_cmd.push   = (state_q == S_PUSH);
  assign q_cmd.tick   = in_fire && (in_data_i.kind == KindTick);
  assign q_cmd.amount = quot_adj[AmtW-1:0];

  wss_pending_queue #(
    .PendingDepth(PendingDepth)
  ) u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (q_cmd),
    .sts_o (q_sts)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = (in_data_i.kind == KindTick) ? S_TICK : S_SCAN;
      end
      S_SCAN: begin
        if (!scan_hit) state_d = S_FACT;
      end
      S_FACT: state_d = S_MULT;
      S_MULT: state_d = S_DIV;
      S_DIV:  state_d = S_PUSH;
      S_PUSH: state_d = S_EMIT;
      S_TICK: begin
        if (q_sts.done) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_d = S_IDLE;
      end
    endcase
  end

  // control registers and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      window_q    <= WindowMsRst;
      gain_q      <= AltGainRst;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgWindowMs: window_q <= cfg_wdata_i[WindowW-1:0];
          CfgAltGain:  gain_q   <= cfg_wdata_i[GainW-1:0];
        endcase
      end
      if (notch_fire && (cnt_q < CapR)) begin
        cnt_q <= cnt_q + RunW'(1);
      end
      // keep only the run of recent notches inside the window
      if ((state_q == S_SCAN) && !scan_hit) begin
        cnt_q <= idx_q;
      end
      if ((state_q == S_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // notch history and arithmetic datapath
  always_ff @(posedge clk_i) begin
    if (notch_fire) begin
      times_q[0] <= in_data_i.time_ms;
      for (int i = 1; i < RecentCap; i++) begin
        times_q[i] <= times_q[i-1];
      end
      now_q   <= in_data_i.time_ms;
      delta_q <= in_data_i.wheel_delta;
      alt_q   <= in_data_i.alt_held;
      idx_q   <= '0;
    end
    if ((state_q == S_SCAN) && scan_hit) begin
      idx_q <= idx_q + RunW'(1);
    end
    if (state_q == S_FACT) begin
      fact_q <= FactW'(FactW'(gain_sel) * (RunBase + FactW'(idx_q)));
    end
    if (state_q == S_MULT) begin
      num_q <= prod_n[DivW-1:0] + DivBias;
    end
    // biased quotient of the divide by six
    if (state_q == S_DIV) begin
      num_q <= DivW'(recip_prod[2*HalfW-1:DivW]);
    end
    if (state_q == S_PUSH) begin
      res_q.scroll_amount <= '0;
      res_q.busy_res      <= 1'b1;
      res_q.dropped       <= q_sts.full;
    end
    if ((state_q == S_TICK) && q_sts.done) begin
      res_q.scroll_amount <= q_sts.amount;
      res_q.busy_res      <= q_sts.nonempty;
      res_q.dropped       <= 1'b0;
    end
    if ((state_q == S_EMIT) && out_free) begin
      out_q <= res_q;
    end
  end

  // checks
  `WSS_ASSERT(a_accept_leaves_idle, clk_i, rst_ni, in_fire |=> (state_q != S_IDLE))
  `WSS_ASSERT(a_result_from_emit, clk_i, rst_ni, $rose(out_valid_q) |-> ($past(state_q) == S_EMIT))
  `WSS_ASSERT_NEVER(a_recent_bound, clk_i, rst_ni, cnt_q > CapR)

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel scroll smoother testbench
// Drives notches and frame ticks through the valid/ready channels, predicts
// every result from its own copy of the notch history and the impulse queue,
// and checks each output transfer field by field. Random idle cycles on both
// sides, a long receiver stall, and register changes between phases.
// ----------------------------------------------------------------------------

// Prediction of the smoother plus the queue of scroll results still owed
class scroll_checker;
  int unsigned          window_ms;
  int unsigned          alt_gain;
  logic [31:0]          notch_log[$];      // newest first
  longint               impulse_amt[$];
  int unsigned          impulse_left[$];
  longint               ramp_weight[wss_pkg::RampSteps + 1];
  wss_pkg::wss_out_t    expected_scrolls[$];
  int unsigned          errors;

  // Q16 raised-cosine weight per steps-left value, Taylor cosine in Q30
  function new();
    longint unsigned offs;
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned term;
    longint unsigned csq;
    longint          cosv;
    window_ms = wss_pkg::WindowMsRst;
    alt_gain  = wss_pkg::AltGainRst;
    errors    = 0;
    ramp_weight[0] = 0;
    for (int s = 1; s <= wss_pkg::RampSteps; s++) begin
      if (2 * s >= wss_pkg::RampSteps) offs = 64'(2 * s - wss_pkg::RampSteps);
      else offs = 64'(wss_pkg::RampSteps - 2 * s);
      ang    = (wss_pkg::PiQ30 * offs) / (2 * wss_pkg::RampSteps);
      ang_sq = (ang * ang) >> 30;
      cosv   = wss_pkg::OneQ30;
      term   = wss_pkg::OneQ30;
      for (int k = 1; k <= 10; k++) begin
        term = ((term * ang_sq) >> 30) / 64'((2 * k - 1) * (2 * k));
        cosv = (k % 2 == 1) ? cosv - longint'(term) : cosv + longint'(term);
      end
      if (cosv < 0) cosv = 0;
      if (cosv > wss_pkg::OneQ30) cosv = wss_pkg::OneQ30;
      csq = cosv;
      csq = (csq * csq) >> 30;
      ramp_weight[s] = longint'((((csq << 17) / wss_pkg::RampSteps) + (64'd1 << 29)) >> 30);
    end
  endfunction

  function void set_reg(logic [wss_pkg::CfgIdxW-1:0] idx, logic [wss_pkg::CfgDataW-1:0] data);
    if (idx == wss_pkg::CfgWindowMs) window_ms = 32'(data);
    else alt_gain = 32'(data[3:0]);
  endfunction

  function int unsigned pending();
    return expected_scrolls.size();
  endfunction

  // Accepted input transfer: advance the state and queue the expected result
  function void note_item(wss_pkg::wss_in_t it);
    wss_pkg::wss_out_t want;
    longint            acc;
    longint            gain_used;
    int unsigned       run;
    logic [31:0]       age;
    want = '0;
    if (it.kind == wss_pkg::KindNotch) begin
      notch_log.push_front(it.time_ms);
      if (notch_log.size() > wss_pkg::RecentCapDef) void'(notch_log.pop_back());
      // keep only the newest run of notches inside the window
      run = 0;
      while (run < notch_log.size()) begin
        age = it.time_ms - notch_log[run];
        if (age > window_ms) break;
        run++;
      end
      while (notch_log.size() > run) void'(notch_log.pop_back());
      gain_used = it.alt_held ? longint'(alt_gain) : 64'sd1;
      acc = longint'(it.wheel_delta) * gain_used * longint'(6 + run) + 3;
      // floor division, round half up
      if (acc % 6 < 0) acc = acc / 6 - 1;
      else acc = acc / 6;
      if (impulse_amt.size() < wss_pkg::PendingDepthDef) begin
        impulse_amt.insert(impulse_amt.size(), acc);
        impulse_left.insert(impulse_left.size(), wss_pkg::RampSteps);
      end else begin
        want.dropped = 1'b1;
      end
    end else begin
      acc = 0;
      for (int i = 0; i < impulse_amt.size(); i++) begin
        acc += impulse_amt[i] * ramp_weight[impulse_left[i]];
        if (impulse_left[i] > 0) impulse_left[i] = impulse_left[i] - 1;
      end
      while (impulse_amt.size() > 0 && impulse_left[0] == 0) begin
        impulse_amt.delete(0);
        impulse_left.delete(0);
      end
      acc = (acc + 32768) >>> 16;
      if (acc > 64'sd2097151) acc = 64'sd2097151;
      if (acc < -64'sd2097152) acc = -64'sd2097152;
      want.scroll_amount = 22'(acc);
    end
    want.busy_res = (impulse_amt.size() != 0);
    expected_scrolls.insert(expected_scrolls.size(), want);
  endfunction

  // Output transfer: compare with the oldest expected result
  function void check_result(wss_pkg::wss_out_t got);
    wss_pkg::wss_out_t want;
    if (expected_scrolls.size() == 0) begin
      $error("result with nothing expected: scroll_amount %0d", got.scroll_amount);
      errors++;
      return;
    end
    want = expected_scrolls[0];
    expected_scrolls.delete(0);
    if (got.scroll_amount !== want.scroll_amount) begin
      $error("scroll_amount: expected %0d, got %0d", want.scroll_amount, got.scroll_amount);
      errors++;
    end
    if (got.busy_res !== want.busy_res) begin
      $error("busy_res: expected %0b, got %0b", want.busy_res, got.busy_res);
      errors++;
    end
    if (got.dropped !== want.dropped) begin
      $error("dropped: expected %0b, got %0b", want.dropped, got.dropped);
      errors++;
    end
  endfunction
endclass

module testbench;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned LongHold   = 300;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         cfg_we_i    = 1'b0;
  logic [wss_pkg::CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [wss_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_ready_o;
  wss_pkg::wss_in_t             in_data_i   = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  wss_pkg::wss_out_t            out_data_o;

  scroll_checker scroll_chk;
  int unsigned   items_sent    = 0;
  bit            quiet_stretch = 1'b0;
  bit            hold_request  = 1'b0;

  wheel_scroll_smoother_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // mostly short idle spans, now and then a long one
  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 80);
  endfunction

  function automatic wss_pkg::wss_in_t notch(logic [15:0] delta, logic [31:0] stamp, logic alt);
    wss_pkg::wss_in_t it;
    it.kind        = wss_pkg::KindNotch;
    it.wheel_delta = delta;
    it.time_ms     = stamp;
    it.alt_held    = alt;
    return it;
  endfunction

  // tick payload fields are don't-care, so fill them with noise
  function automatic wss_pkg::wss_in_t frame_tick();
    wss_pkg::wss_in_t it;
    it.kind        = wss_pkg::KindTick;
    it.wheel_delta = 16'($urandom());
    it.time_ms     = $urandom();
    it.alt_held    = 1'($urandom());
    return it;
  endfunction

  // offer one item, optionally after an idle gap, and wait for its transfer
  task automatic send_item(input wss_pkg::wss_in_t it);
    int unsigned gap;
    gap = (!quiet_stretch && $urandom_range(0, 99) < 35) ? idle_span() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // stop offering and wait until every expected result has left the block
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (scroll_chk.pending() != 0);
  endtask

  task automatic write_reg(input logic [wss_pkg::CfgIdxW-1:0] idx,
                           input logic [wss_pkg::CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    scroll_chk.set_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // both transfer sides are observed at the clock edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) scroll_chk.note_item(in_data_i);
      if (out_valid_o && out_ready_i) scroll_chk.check_result(out_data_o);
    end
  end

  // result receiver: random stalls, plus a long hold on request
  initial begin : result_sink
    int unsigned stall;
    stall = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        stall = LongHold;
      end else if (stall == 0 && !quiet_stretch && $urandom_range(0, 99) < 20) begin
        stall = idle_span();
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    wss_pkg::wss_in_t it;
    logic [31:0]      t_ms;
    logic [15:0]      d;
    logic [15:0]      win;
    logic [15:0]      gain_word;
    int unsigned      stop_at;
    int unsigned      n;
    int unsigned      burst;
    bit               flood;
    bit               neg;
    scroll_chk = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty tick, field extremes, window edge, backward time, wrap
    send_item(frame_tick());
    send_item(notch(16'h7FFF, 32'd0, 1'b0));
    send_item(notch(16'h8000, 32'd100, 1'b1));
    send_item(notch(16'h0000, 32'd600, 1'b1));
    send_item(notch(16'h0001, 32'hFFFF_FFF0, 1'b0));
    send_item(notch(16'hFFFF, 32'h0000_0010, 1'b1));
    repeat (19) send_item(frame_tick());
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin win = 16'd65535; gain_word = 16'd15; end
        1: begin win = 16'd0;     gain_word = 16'd0;  end
        2: begin win = 16'd1;     gain_word = 16'd1;  end
        3: begin win = 16'd500;   gain_word = 16'd5;  end
        6: begin win = 16'($urandom()); gain_word = 16'($urandom()); end   // junk above the gain bits
        7: begin win = 16'd40;    gain_word = 16'd15; end
        default: begin
          win       = 16'($urandom_range(2, 2000));
          gain_word = 16'($urandom_range(0, 15));
        end
      endcase
      write_reg(wss_pkg::CfgWindowMs, win);
      write_reg(wss_pkg::CfgAltGain, gain_word);
      t_ms = ($urandom_range(0, 3) == 0) ? (32'hFFFF_FF00 | $urandom_range(0, 255)) : $urandom();

      // back-pressure: receiver holds off while items keep coming
      if (p == 2 || p == 5) begin
        quiet_stretch = 1'b1;
        hold_request  = 1'b1;
        repeat (16) begin
          if ($urandom_range(0, 1)) begin
            t_ms += $urandom_range(0, 30);
            send_item(notch(16'($urandom()), t_ms, 1'($urandom_range(0, 1))));
          end else begin
            send_item(frame_tick());
          end
        end
        quiet_stretch = 1'b0;
      end

      stop_at = items_sent + 150;
      burst = 0;
      while (items_sent < stop_at) begin
        quiet_stretch = ($urandom_range(0, 99) < 15);
        if ($urandom_range(0, 99) < 10) begin
          // noise item
          it.kind        = 1'($urandom());
          it.wheel_delta = 16'($urandom());
          it.time_ms     = $urandom();
          it.alt_held    = 1'($urandom());
          send_item(it);
        end else begin
          // a run of notches followed by frame ticks; a flood can overrun the queue
          flood = (burst == 0 && (p == 0 || p == 7)) || $urandom_range(0, 99) < 10;
          neg   = (burst == 0) ? (p == 7) : ($urandom_range(0, 1) == 1);
          n     = flood ? $urandom_range(30, 40) : $urandom_range(1, 6);
          repeat (n) begin
            if (flood) begin
              t_ms += $urandom_range(0, 3);
              d = neg ? 16'h8000 + 16'($urandom_range(0, 400))
                      : 16'h7FFF - 16'($urandom_range(0, 400));
              send_item(notch(d, t_ms, 1'b1));
            end else begin
              case ($urandom_range(0, 9))
                0, 1, 2: t_ms += $urandom_range(0, 40);
                3, 4:    t_ms += $urandom_range(0, scroll_chk.window_ms);
                5:       t_ms += 0;
                6:       t_ms += scroll_chk.window_ms;
                7:       t_ms += scroll_chk.window_ms + 1;
                8:       t_ms += $urandom_range(0, 4 * scroll_chk.window_ms + 8);
                default: t_ms = $urandom();
              endcase
              d = ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 240)) : 16'($urandom());
              if ($urandom_range(0, 1)) d = -d;
              send_item(notch(d, t_ms, $urandom_range(0, 99) < 30));
            end
          end
          n = flood ? $urandom_range(12, 30) : $urandom_range(1, 30);
          repeat (n) begin
            send_item(frame_tick());
            t_ms += 16;
          end
        end
        burst++;
      end
      quiet_stretch = 1'b0;
      settle();
    end

    // let any stray output show up before the verdict
    repeat (64) @(posedge clk_i);
    if (scroll_chk.errors == 0 && scroll_chk.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/wss_pkg.sv
src/wss_pending_queue.sv
src/wheel_scroll_smoother_unit.sv
verif/testbench.sv
